// ----- rtl/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation codes, widths and the request entry passed from front to back.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_FRAC_BITS   = 16;
    localparam int CAU_DATA_W      = 32;
    localparam int CAU_SUM_W       = CAU_DATA_W + 1;
    localparam int CAU_PROD_W      = 2 * CAU_DATA_W;
    localparam int CAU_TERM_W      = CAU_PROD_W + 2;
    localparam int CAU_QBITS       = CAU_DATA_W;
    localparam int CAU_REM_W       = CAU_PROD_W + CAU_QBITS;
    localparam int CAU_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Classified request: operand sign/magnitude plus add/sub result
    typedef struct packed {
        op_t                   op;
        logic                  dz;
        logic                  ar_neg;
        logic [CAU_DATA_W-1:0] ar_mag;
        logic                  ai_neg;
        logic [CAU_DATA_W-1:0] ai_mag;
        logic                  br_neg;
        logic [CAU_DATA_W-1:0] br_mag;
        logic                  bi_neg;
        logic [CAU_DATA_W-1:0] bi_mag;
        logic                  re_as_neg;
        logic [CAU_SUM_W-1:0]  re_as_mag;
        logic                  im_as_neg;
        logic [CAU_SUM_W-1:0]  im_as_mag;
    } cau_entry_t;

endpackage

// ----- rtl/cau_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if: operand request channel
// Valid/ready channel carrying the operation code and both complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic signed [cau_pkg::CAU_DATA_W-1:0] a_re;
    logic signed [cau_pkg::CAU_DATA_W-1:0] a_im;
    logic signed [cau_pkg::CAU_DATA_W-1:0] b_re;
    logic signed [cau_pkg::CAU_DATA_W-1:0] b_im;

    modport source (output valid, output operation, output a_re, output a_im,
                    output b_re, output b_im, input ready);
    modport sink   (input valid, input operation, input a_re, input a_im,
                    input b_re, input b_im, output ready);
endinterface

// ----- rtl/cau_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_rsp_if: result channel
// Valid/ready channel carrying the complex result and its status flags.
// ----------------------------------------------------------------------------
interface cau_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cau_pkg::CAU_DATA_W-1:0] res_re;
    logic signed [cau_pkg::CAU_DATA_W-1:0] res_im;
    logic                                  overflow;
    logic                                  div_by_zero;

    modport source (output valid, output res_re, output res_im, output overflow,
                    output div_by_zero, input ready);
    modport sink   (input valid, input res_re, input res_im, input overflow,
                    input div_by_zero, output ready);
endinterface

// ----- rtl/cau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: request intake and classification
// Splits operands into sign/magnitude, does add/sub, flags a zero divisor.
// ----------------------------------------------------------------------------
module cau_front (
    cau_req_if.sink             req,
    input  logic                full,
    output logic                push,
    output cau_pkg::cau_entry_t entry
);
    import cau_pkg::*;

    logic signed [CAU_SUM_W-1:0] sum_re;
    logic signed [CAU_SUM_W-1:0] sum_im;
    op_t                         op;

    function automatic logic [CAU_DATA_W-1:0] mag_of(logic signed [CAU_DATA_W-1:0] x);
        mag_of = x[CAU_DATA_W-1] ? CAU_DATA_W'(-x) : CAU_DATA_W'(x);
    endfunction

    function automatic logic [CAU_SUM_W-1:0] mag_sum(logic signed [CAU_SUM_W-1:0] x);
        mag_sum = x[CAU_SUM_W-1] ? CAU_SUM_W'(-x) : CAU_SUM_W'(x);
    endfunction

    // handshake: take a request whenever the queue has room
    assign req.ready = !full;
    assign push      = req.valid && !full;
    assign op        = op_t'(req.operation);

    // add / subtract done up front, exact in 33 bits
    always_comb
    begin
        if (op == OP_SUB)
        begin
            sum_re = CAU_SUM_W'(req.a_re) - CAU_SUM_W'(req.b_re);
            sum_im = CAU_SUM_W'(req.a_im) - CAU_SUM_W'(req.b_im);
        end
        else
        begin
            sum_re = CAU_SUM_W'(req.a_re) + CAU_SUM_W'(req.b_re);
            sum_im = CAU_SUM_W'(req.a_im) + CAU_SUM_W'(req.b_im);
        end
    end

    // classified entry
    always_comb
    begin
        entry.op        = op;
        entry.dz        = (op == OP_DIV) && (req.b_re == '0) && (req.b_im == '0);
        entry.ar_neg    = req.a_re[CAU_DATA_W-1];
        entry.ar_mag    = mag_of(req.a_re);
        entry.ai_neg    = req.a_im[CAU_DATA_W-1];
        entry.ai_mag    = mag_of(req.a_im);
        entry.br_neg    = req.b_re[CAU_DATA_W-1];
        entry.br_mag    = mag_of(req.b_re);
        entry.bi_neg    = req.b_im[CAU_DATA_W-1];
        entry.bi_mag    = mag_of(req.b_im);
        entry.re_as_neg = sum_re[CAU_SUM_W-1];
        entry.re_as_mag = mag_sum(sum_re);
        entry.im_as_neg = sum_im[CAU_SUM_W-1];
        entry.im_as_mag = mag_sum(sum_im);
    end

endmodule

// ----- rtl/cau_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue: request queue between front and back
// Small FIFO of classified requests; decouples front and back stalls.
// ----------------------------------------------------------------------------
module cau_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cau_pkg::cau_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output cau_pkg::cau_entry_t rd_entry
);
    import cau_pkg::*;

    localparam int PTR_W = $clog2(CAU_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CAU_QUEUE_DEPTH + 1);

    cau_entry_t       slot_reg [CAU_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(CAU_QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- rtl/cau_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back: execution pipeline
// Products, signed sums, restoring divider one quotient bit per stage,
// saturation and the output register. Whole pipeline stalls together.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cau_pkg::cau_entry_t q_entry,
    output logic                pop,
    cau_rsp_if.source           rsp
);
    import cau_pkg::*;

    localparam int NSTG = CAU_QBITS + 1;

    typedef struct packed {
        op_t                        op;
        logic                       dz;
        logic                       re_as_neg;
        logic [CAU_SUM_W-1:0]       re_as_mag;
        logic                       im_as_neg;
        logic [CAU_SUM_W-1:0]       im_as_mag;
        logic [3:0]                 pneg;
        logic [3:0][CAU_PROD_W-1:0] prod;
        logic [1:0][CAU_PROD_W-1:0] sq;
    } s1_t;

    typedef struct packed {
        op_t                        op;
        logic                       dz;
        logic                       re_as_neg;
        logic [CAU_SUM_W-1:0]       re_as_mag;
        logic                       im_as_neg;
        logic [CAU_SUM_W-1:0]       im_as_mag;
        logic [3:0][CAU_TERM_W-1:0] term;
        logic [CAU_PROD_W-1:0]      den;
    } s2_t;

    typedef struct packed {
        op_t                   op;
        logic                  dz;
        logic                  re_as_neg;
        logic [CAU_SUM_W-1:0]  re_as_mag;
        logic                  im_as_neg;
        logic [CAU_SUM_W-1:0]  im_as_mag;
        logic [CAU_TERM_W-1:0] re_s;
        logic [CAU_TERM_W-1:0] im_s;
        logic [CAU_PROD_W-1:0] den;
    } s3_t;

    typedef struct packed {
        logic                  neg;
        logic [CAU_REM_W-1:0]  rem;
        logic [CAU_PROD_W-1:0] val;
    } lane_t;

    typedef struct packed {
        logic                  active;
        logic                  dz;
        logic [CAU_PROD_W-1:0] den;
        lane_t                 re;
        lane_t                 im;
    } dv_t;

    logic en;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    dv_t  s4_reg, s4_next;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    dv_t  dv_reg [NSTG];
    dv_t  dv_next [NSTG];
    logic [NSTG-1:0] dv_valid_reg;

    logic                  out_valid_reg;
    logic [CAU_DATA_W-1:0] out_re_reg, out_re_next;
    logic [CAU_DATA_W-1:0] out_im_reg, out_im_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_dz_reg;
    logic [CAU_DATA_W:0]   sat_re;
    logic [CAU_DATA_W:0]   sat_im;

    function automatic logic [CAU_TERM_W-1:0] signed_term(logic neg,
                                                          logic [CAU_PROD_W-1:0] p);
        signed_term = neg ? CAU_TERM_W'(0) - CAU_TERM_W'(p) : CAU_TERM_W'(p);
    endfunction

    function automatic logic [CAU_PROD_W-1:0] abs_term(logic [CAU_TERM_W-1:0] x);
        logic [CAU_TERM_W-1:0] a;
        a = x[CAU_TERM_W-1] ? CAU_TERM_W'(0) - x : x;
        abs_term = a[CAU_PROD_W-1:0];
    endfunction

    // one restoring step: quotient bit sh of (rem / den)
    function automatic lane_t div_step(lane_t l, logic act, logic [CAU_PROD_W-1:0] den,
                                       int sh);
        logic [CAU_REM_W-1:0] d;
        lane_t r;
        r = l;
        d = CAU_REM_W'(den) << sh;
        if (act && (l.rem >= d))
        begin
            r.rem = l.rem - d;
            r.val = l.val | (CAU_PROD_W'(1) << sh);
        end
        div_step = r;
    endfunction

    // saturate sign/magnitude to 32 bits: {overflow, value}
    function automatic logic [CAU_DATA_W:0] sat32(lane_t l);
        logic [CAU_DATA_W:0] r;
        if (!l.neg)
        begin
            if (l.val > CAU_PROD_W'({1'b0, {(CAU_DATA_W-1){1'b1}}}))
                r = {1'b1, 1'b0, {(CAU_DATA_W-1){1'b1}}};
            else
                r = {1'b0, l.val[CAU_DATA_W-1:0]};
        end
        else
        begin
            if (l.val > CAU_PROD_W'({1'b1, {(CAU_DATA_W-1){1'b0}}}))
                r = {1'b1, 1'b1, {(CAU_DATA_W-1){1'b0}}};
            else
                r = {1'b0, CAU_DATA_W'(0) - l.val[CAU_DATA_W-1:0]};
        end
        sat32 = r;
    endfunction

    // global advance: output slot empty or being taken
    assign en  = !out_valid_reg || rsp.ready;
    assign pop = en && q_valid;

    // stage 1: six 32x32 magnitude products
    always_comb
    begin
        s1_next.op        = q_entry.op;
        s1_next.dz        = q_entry.dz;
        s1_next.re_as_neg = q_entry.re_as_neg;
        s1_next.re_as_mag = q_entry.re_as_mag;
        s1_next.im_as_neg = q_entry.im_as_neg;
        s1_next.im_as_mag = q_entry.im_as_mag;
        s1_next.prod[0]   = q_entry.ar_mag * q_entry.br_mag;
        s1_next.prod[1]   = q_entry.ai_mag * q_entry.bi_mag;
        s1_next.prod[2]   = q_entry.ai_mag * q_entry.br_mag;
        s1_next.prod[3]   = q_entry.ar_mag * q_entry.bi_mag;
        s1_next.pneg[0]   = q_entry.ar_neg ^ q_entry.br_neg;
        s1_next.pneg[1]   = q_entry.ai_neg ^ q_entry.bi_neg;
        s1_next.pneg[2]   = q_entry.ai_neg ^ q_entry.br_neg;
        s1_next.pneg[3]   = q_entry.ar_neg ^ q_entry.bi_neg;
        s1_next.sq[0]     = q_entry.br_mag * q_entry.br_mag;
        s1_next.sq[1]     = q_entry.bi_mag * q_entry.bi_mag;
    end

    // stage 2: signed terms (mul subtracts in re, div in im), divisor
    always_comb
    begin
        s2_next.op        = s1_reg.op;
        s2_next.dz        = s1_reg.dz;
        s2_next.re_as_neg = s1_reg.re_as_neg;
        s2_next.re_as_mag = s1_reg.re_as_mag;
        s2_next.im_as_neg = s1_reg.im_as_neg;
        s2_next.im_as_mag = s1_reg.im_as_mag;
        s2_next.term[0]   = signed_term(s1_reg.pneg[0], s1_reg.prod[0]);
        s2_next.term[1]   = signed_term(s1_reg.pneg[1] ^ (s1_reg.op == OP_MUL),
                                        s1_reg.prod[1]);
        s2_next.term[2]   = signed_term(s1_reg.pneg[2], s1_reg.prod[2]);
        s2_next.term[3]   = signed_term(s1_reg.pneg[3] ^ (s1_reg.op == OP_DIV),
                                        s1_reg.prod[3]);
        s2_next.den       = s1_reg.sq[0] + s1_reg.sq[1];
    end

    // stage 3: full precision sums
    always_comb
    begin
        s3_next.op        = s2_reg.op;
        s3_next.dz        = s2_reg.dz;
        s3_next.re_as_neg = s2_reg.re_as_neg;
        s3_next.re_as_mag = s2_reg.re_as_mag;
        s3_next.im_as_neg = s2_reg.im_as_neg;
        s3_next.im_as_mag = s2_reg.im_as_mag;
        s3_next.re_s      = s2_reg.term[0] + s2_reg.term[1];
        s3_next.im_s      = s2_reg.term[2] + s2_reg.term[3];
        s3_next.den       = s2_reg.den;
    end

    // stage 4: sign/magnitude per operation, divider setup
    always_comb
    begin
        s4_next.active = 1'b0;
        s4_next.dz     = s3_reg.dz;
        s4_next.den    = s3_reg.den;
        s4_next.re     = '0;
        s4_next.im     = '0;
        case (s3_reg.op)
            OP_ADD, OP_SUB:
            begin
                s4_next.re.neg = s3_reg.re_as_neg;
                s4_next.re.val = CAU_PROD_W'(s3_reg.re_as_mag);
                s4_next.im.neg = s3_reg.im_as_neg;
                s4_next.im.val = CAU_PROD_W'(s3_reg.im_as_mag);
            end
            OP_MUL:
            begin
                s4_next.re.neg = s3_reg.re_s[CAU_TERM_W-1];
                s4_next.re.val = abs_term(s3_reg.re_s) >> FRAC_BITS;
                s4_next.im.neg = s3_reg.im_s[CAU_TERM_W-1];
                s4_next.im.val = abs_term(s3_reg.im_s) >> FRAC_BITS;
            end
            OP_DIV:
            begin
                if (!s3_reg.dz)
                begin
                    s4_next.active = 1'b1;
                    s4_next.re.neg = s3_reg.re_s[CAU_TERM_W-1];
                    s4_next.re.rem = CAU_REM_W'(abs_term(s3_reg.re_s)) << FRAC_BITS;
                    s4_next.im.neg = s3_reg.im_s[CAU_TERM_W-1];
                    s4_next.im.rem = CAU_REM_W'(abs_term(s3_reg.im_s)) << FRAC_BITS;
                end
            end
            default:
            begin
                s4_next.active = 1'b0;
            end
        endcase
    end

    // front stages: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // front stages: payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    // divider: stage k resolves quotient bit CAU_QBITS-k; bit 32 means saturate
    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            always_comb
            begin
                dv_next[k]    = s4_reg;
                dv_next[k].re = div_step(s4_reg.re, s4_reg.active, s4_reg.den, CAU_QBITS);
                dv_next[k].im = div_step(s4_reg.im, s4_reg.active, s4_reg.den, CAU_QBITS);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_valid_reg[k] <= 1'b0;
                else if (en)
                    dv_valid_reg[k] <= s4_valid_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                dv_next[k]    = dv_reg[k-1];
                dv_next[k].re = div_step(dv_reg[k-1].re, dv_reg[k-1].active,
                                         dv_reg[k-1].den, CAU_QBITS - k);
                dv_next[k].im = div_step(dv_reg[k-1].im, dv_reg[k-1].active,
                                         dv_reg[k-1].den, CAU_QBITS - k);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_valid_reg[k] <= 1'b0;
                else if (en)
                    dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k] <= dv_next[k];
        end
    end

    // saturation into output register
    always_comb
    begin
        sat_re       = sat32(dv_reg[NSTG-1].re);
        sat_im       = sat32(dv_reg[NSTG-1].im);
        out_re_next  = sat_re[CAU_DATA_W-1:0];
        out_im_next  = sat_im[CAU_DATA_W-1:0];
        out_ovf_next = sat_re[CAU_DATA_W] | sat_im[CAU_DATA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[NSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg  <= out_re_next;
            out_im_reg  <= out_im_next;
            out_ovf_reg <= out_ovf_next;
            out_dz_reg  <= dv_reg[NSTG-1].dz;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.res_re      = out_re_reg;
    assign rsp.res_im      = out_im_reg;
    assign rsp.overflow    = out_ovf_reg;
    assign rsp.div_by_zero = out_dz_reg;

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one request per cycle while results are taken; set by the 33-stage
//   restoring divider, one quotient bit per stage, which takes a new pair each cycle.
// A stalled result holds the whole back pipeline; the 2-entry queue fills up,
//   then intake stalls until the result is taken.
// Reset (rst_n, async active low) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex add/sub/mul/div in signed Q16.16
// Front classifies requests, a queue decouples it from the execution pipeline.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   operand_ch,
    cau_rsp_if.source result_ch
);
    import cau_pkg::*;

    logic       push;
    logic       full;
    logic       pop;
    logic       rd_valid;
    cau_entry_t wr_entry;
    cau_entry_t rd_entry;

    // intake and classification
    cau_front u_front (
        .req   (operand_ch),
        .full  (full),
        .push  (push),
        .entry (wr_entry)
    );

    // decoupling queue
    cau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    // execution pipeline
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (rd_valid),
        .q_entry (rd_entry),
        .pop     (pop),
        .rsp     (result_ch)
    );

endmodule
